// ----- rtl/core/ptns_pkg.sv -----
// Package: shared types and constants for the position table search block.
package ptns_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam logic [31:0] AGE_LIMIT_RESET = 32'd60;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_NEAREST = 2'd2,
        OP_PURGE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

// ----- rtl/core/ptns_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ptns_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/ptns_dist.sv -----
// Pipelined squared distance between a stored point and the query point.
module ptns_dist #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    output logic [2*COORD_WIDTH+1:0]      o_dist
);
    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned HW = (DW + 1) / 2;
    localparam int unsigned LW = DW - HW;
    localparam int unsigned SW = 2 * COORD_WIDTH + 2;

    logic signed [DW-1:0] dx, dy, dz;
    logic [DW-1:0] n_mx, n_my, n_mz;
    logic [DW-1:0] r_mx, r_my, r_mz;
    logic [2*DW-1:0] r_px_ll, r_px_hl, r_px_hh;
    logic [2*DW-1:0] r_py_ll, r_py_hl, r_py_hh;
    logic [2*DW-1:0] r_pz_ll, r_pz_hl, r_pz_hh;
    logic [2*DW-1:0] n_sx, n_sy, n_sz;

    // take absolute differences
    always_comb begin
        dx = DW'(i_ax) - DW'(i_bx);
        dy = DW'(i_ay) - DW'(i_by);
        dz = DW'(i_az) - DW'(i_bz);
        n_mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        n_my = dy[DW-1] ? DW'(-dy) : DW'(dy);
        n_mz = dz[DW-1] ? DW'(-dz) : DW'(dz);
    end

    // stage 1: magnitudes, stage 2: split partial products
    always_ff @(posedge i_clk) begin
        r_mx <= n_mx;
        r_my <= n_my;
        r_mz <= n_mz;
        r_px_ll <= (2*DW)'(r_mx[LW-1:0]) * (2*DW)'(r_mx[LW-1:0]);
        r_px_hl <= (2*DW)'(r_mx[DW-1:LW]) * (2*DW)'(r_mx[LW-1:0]);
        r_px_hh <= (2*DW)'(r_mx[DW-1:LW]) * (2*DW)'(r_mx[DW-1:LW]);
        r_py_ll <= (2*DW)'(r_my[LW-1:0]) * (2*DW)'(r_my[LW-1:0]);
        r_py_hl <= (2*DW)'(r_my[DW-1:LW]) * (2*DW)'(r_my[LW-1:0]);
        r_py_hh <= (2*DW)'(r_my[DW-1:LW]) * (2*DW)'(r_my[DW-1:LW]);
        r_pz_ll <= (2*DW)'(r_mz[LW-1:0]) * (2*DW)'(r_mz[LW-1:0]);
        r_pz_hl <= (2*DW)'(r_mz[DW-1:LW]) * (2*DW)'(r_mz[LW-1:0]);
        r_pz_hh <= (2*DW)'(r_mz[DW-1:LW]) * (2*DW)'(r_mz[DW-1:LW]);
    end

    // recombine squares
    always_comb begin
        n_sx = r_px_ll + (r_px_hl << (LW + 1)) + (r_px_hh << (2 * LW));
        n_sy = r_py_ll + (r_py_hl << (LW + 1)) + (r_py_hh << (2 * LW));
        n_sz = r_pz_ll + (r_pz_hl << (LW + 1)) + (r_pz_hh << (2 * LW));
    end

    // stage 3: sum of squares
    always_ff @(posedge i_clk) begin
        o_dist <= SW'(n_sx) + SW'(n_sy) + SW'(n_sz);
    end
endmodule

// ----- rtl/core/position_table_nearest_search.sv -----
// Top level: position table with update, lookup, nearest search and purge.
// Every operation sweeps all slots, one memory read per cycle.
// After the slot scan the read pipeline drains, an update then writes its slot,
// and the result is presented; one operation at a time, next beat taken
// once the result is handed over. Throughput is set by the slot scan.
// Reset clears all valid bits (flip-flops) and loads the age limit with 60.
module position_table_nearest_search #(
    parameter int unsigned TABLE_DEPTH = ptns_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned COORD_WIDTH = ptns_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_entry_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0] i_current_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_id,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [6:0]  o_removed_count
);
    import ptns_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SW = 2 * COORD_WIDTH + 2;
    localparam int unsigned EW = 32 + 3 * COORD_WIDTH + 32;
    localparam int unsigned DLY = 4;

    t_state r_state, n_state;
    logic [31:0] r_age;
    logic [TABLE_DEPTH-1:0] r_vld, n_vld;
    logic [AW:0] r_rd, n_rd;
    logic [1:0] r_op;
    logic [31:0] r_key, r_now;
    logic signed [COORD_WIDTH-1:0] r_qx, r_qy, r_qz;
    // read pipeline tags
    logic [DLY-1:0] r_tv;
    logic [AW-1:0] r_ta [DLY];
    logic [31:0] r_kd [DLY-1];
    // scan results
    logic r_hit, r_free_f, r_best_f;
    logic [AW-1:0] r_hit_a, r_free_a;
    logic [SW-1:0] r_best;
    logic [31:0] r_best_id;
    logic [CW-1:0] r_rem;
    logic [1:0] r_st;
    logic [31:0] r_rid;
    logic signed [COORD_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic [6:0] r_rc;

    logic [EW-1:0] wdata, rdata;
    logic we;
    logic [AW-1:0] waddr;
    logic [31:0] d_key, d_stamp;
    logic signed [COORD_WIDTH-1:0] d_x, d_y, d_z;
    logic [SW-1:0] sq_dist;
    logic acc;
    logic [AW-1:0] a1, a4;
    logic v1, v4;
    logic [31:0] age;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    ptns_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_rd[AW-1:0]), .o_rdata(rdata)
    );

    assign {d_key, d_x, d_y, d_z, d_stamp} = rdata;

    ptns_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
        .i_clk(i_clk), .i_ax(d_x), .i_ay(d_y), .i_az(d_z),
        .i_bx(r_qx), .i_by(r_qy), .i_bz(r_qz), .o_dist(sq_dist)
    );

    assign a1 = r_ta[0];
    assign v1 = r_tv[0];
    assign a4 = r_ta[DLY-1];
    assign v4 = r_tv[DLY-1];
    assign age = r_now - d_stamp;

    // update writes the chosen slot, the key in the top bits
    assign we = (r_state == S_WRITE) && (r_hit || r_free_f);
    assign waddr = r_hit ? r_hit_a : r_free_a;
    assign wdata = {r_key, r_qx, r_qy, r_qz, r_now};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= AGE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_age <= i_cfg_wdata;
        end
    end

    // capture the operation on an accepted beat
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_opcode;
            r_key <= i_entry_id;
            r_now <= i_current_time;
            r_qx  <= COORD_WIDTH'(i_pos_x);
            r_qy  <= COORD_WIDTH'(i_pos_y);
            r_qz  <= COORD_WIDTH'(i_pos_z);
        end
    end

    // state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_rd    <= '0;
            r_tv    <= '0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_rd    <= n_rd;
            r_tv    <= {r_tv[DLY-2:0], (r_state == S_SCAN)};
        end
    end

    // address and key tags follow the read pipeline
    always_ff @(posedge i_clk) begin
        r_ta[0] <= r_rd[AW-1:0];
        for (int k = 1; k < DLY; k++) begin
            r_ta[k] <= r_ta[k-1];
        end
        r_kd[0] <= d_key;
        for (int k = 1; k < DLY - 1; k++) begin
            r_kd[k] <= r_kd[k-1];
        end
    end

    // next state, scan bookkeeping
    always_comb begin
        n_state = r_state;
        n_vld   = r_vld;
        n_rd    = r_rd;
        unique case (r_state)
            S_IDLE: begin
                n_rd = '0;
                if (acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_rd = r_rd + 1'b1;
                if (r_rd == (AW+1)'(TABLE_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_tv == '0) begin
                    n_state = (t_opcode'(r_op) == OP_UPDATE) ? S_WRITE : S_OUT;
                end
            end
            S_WRITE: begin
                if (r_hit || r_free_f) begin
                    n_vld[waddr] = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // drop stale entries as the purge scan sees them
        if (v1 && t_opcode'(r_op) == OP_PURGE && r_vld[a1] && r_now >= d_stamp
                && age > r_age) begin
            n_vld[a1] = 1'b0;
        end
    end

    // scan accumulators
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_hit    <= 1'b0;
            r_free_f <= 1'b0;
            r_best_f <= 1'b0;
            r_rem    <= '0;
        end else begin
            if (v1 && r_vld[a1] && d_key == r_key && !r_hit) begin
                r_hit   <= 1'b1;
                r_hit_a <= a1;
                r_ox <= d_x;
                r_oy <= d_y;
                r_oz <= d_z;
            end
            if (v1 && !r_vld[a1] && !r_free_f) begin
                r_free_f <= 1'b1;
                r_free_a <= a1;
            end
            if (v1 && t_opcode'(r_op) == OP_PURGE && r_vld[a1] && r_now >= d_stamp
                    && age > r_age) begin
                r_rem <= r_rem + 1'b1;
            end
            if (v4 && r_vld[a4] && (!r_best_f || sq_dist < r_best)) begin
                r_best_f  <= 1'b1;
                r_best    <= sq_dist;
                r_best_id <= r_kd[DLY-2];
            end
        end
    end

    // form the result beat
    always_comb begin
        r_st = ST_OK;
        r_rid = '0;
        r_rc = '0;
        unique case (t_opcode'(r_op))
            OP_UPDATE:  r_st = (r_hit || r_free_f) ? ST_OK : ST_FULL;
            OP_LOOKUP:  r_st = r_hit ? ST_OK : ST_NOT_FOUND;
            OP_NEAREST: begin
                r_st  = r_best_f ? ST_OK : ST_EMPTY;
                r_rid = r_best_f ? r_best_id : '0;
            end
            OP_PURGE:   r_rc = 7'(r_rem);
            default:    r_st = ST_OK;
        endcase
    end

    assign o_valid = (r_state == S_OUT);
    assign o_status = r_st;
    assign o_result_id = r_rid;
    assign o_out_x = (t_opcode'(r_op) == OP_LOOKUP && r_hit) ? 32'(r_ox) : '0;
    assign o_out_y = (t_opcode'(r_op) == OP_LOOKUP && r_hit) ? 32'(r_oy) : '0;
    assign o_out_z = (t_opcode'(r_op) == OP_LOOKUP && r_hit) ? 32'(r_oz) : '0;
    assign o_removed_count = r_rc;
endmodule

// ----- test/tb_position_table_nearest_search.sv -----
// Testbench for the position table: directed table plus random traffic, checked by a predictor.
module tb_position_table_nearest_search;
    timeunit 1ns;
    timeprecision 1ps;
    import ptns_pkg::*;

    localparam int DEPTH = 64;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic i_valid, o_stall, o_valid, i_stall;
    logic [1:0] i_opcode;
    logic [31:0] i_entry_id, i_current_time;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [1:0] o_status;
    logic [31:0] o_result_id;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic [6:0] o_removed_count;

    position_table_nearest_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_opcode(i_opcode), .i_entry_id(i_entry_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_current_time(i_current_time), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_result_id(o_result_id), .o_out_x(o_out_x),
        .o_out_y(o_out_y), .o_out_z(o_out_z), .o_removed_count(o_removed_count)
    );

    typedef struct packed {
        t_opcode     op;
        logic [31:0] id;
        logic [31:0] x, y, z;
        logic [31:0] now;
    } t_request;

    typedef struct packed {
        t_status     st;
        logic [31:0] rid;
        logic [31:0] x, y, z;
        logic [6:0]  removed;
    } t_answer;

    // Shadow table state
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_key [DEPTH];
    logic signed [31:0] tbl_x [DEPTH], tbl_y [DEPTH], tbl_z [DEPTH];
    logic [31:0] tbl_stamp [DEPTH];
    logic [31:0] age_limit;

    t_answer answers_due[$];
    int      errors;
    bit      calm;      // no idling in the final stretch
    logic [31:0] known_ids[$];

    function automatic logic [65:0] dist_sq(int s, logic signed [31:0] qx,
                                            logic signed [31:0] qy, logic signed [31:0] qz);
        logic signed [65:0] dx, dy, dz;
        dx = tbl_x[s] - qx;
        dy = tbl_y[s] - qy;
        dz = tbl_z[s] - qz;
        return 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
    endfunction

    function automatic int slot_of(logic [31:0] key);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_key[i] == key) return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and return the answer it must produce
    function automatic t_answer table_apply(t_request r);
        t_answer a;
        int s;
        bit found;
        logic [65:0] best, d;
        a = '0;
        a.st = ST_OK;
        case (r.op)
            OP_UPDATE: begin
                s = slot_of(r.id);
                if (s < 0)
                    for (int i = 0; i < DEPTH; i++)
                        if (!tbl_valid[i]) begin s = i; break; end
                if (s < 0) a.st = ST_FULL;
                else begin
                    tbl_valid[s] = 1'b1; tbl_key[s] = r.id;
                    tbl_x[s] = r.x; tbl_y[s] = r.y; tbl_z[s] = r.z;
                    tbl_stamp[s] = r.now;
                end
            end
            OP_LOOKUP: begin
                s = slot_of(r.id);
                if (s < 0) a.st = ST_NOT_FOUND;
                else begin a.x = tbl_x[s]; a.y = tbl_y[s]; a.z = tbl_z[s]; end
            end
            OP_NEAREST: begin
                found = 0; best = '0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!tbl_valid[i]) continue;
                    d = dist_sq(i, r.x, r.y, r.z);
                    if (!found || d < best) begin
                        found = 1; best = d; a.rid = tbl_key[i];
                    end
                end
                if (!found) a.st = ST_EMPTY;
            end
            default: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && r.now >= tbl_stamp[i] &&
                        (r.now - tbl_stamp[i]) > age_limit) begin
                        tbl_valid[i] = 1'b0;
                        a.removed++;
                    end
            end
        endcase
        return a;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("position_table_nearest_search verification failed");
        $finish;
    end

    // Receiver: random stall bursts, compare each accepted beat
    int stall_left;
    initial begin
        i_stall = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result beat", $time);
                    errors++;
                end else begin
                    t_answer e, g;
                    e = answers_due.pop_front();
                    g = '{t_status'(o_status), o_result_id, o_out_x, o_out_y, o_out_z,
                          o_removed_count};
                    if (g !== e) begin
                        $display("%0t: mismatch expected st=%0d id=%h xyz=%h %h %h rm=%0d",
                                 $time, e.st, e.rid, e.x, e.y, e.z, e.removed);
                        $display("%0t:          actual st=%0d id=%h xyz=%h %h %h rm=%0d",
                                 $time, g.st, g.rid, g.x, g.y, g.z, g.removed);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) stall_left--;
            else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
            i_stall <= (stall_left > 0);
        end
    end

    task automatic send(t_request r);
        t_answer a;
        // start on a fresh edge so the drop of the last beat stands alone
        @(posedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= r.op; i_entry_id <= r.id;
        i_pos_x <= r.x; i_pos_y <= r.y; i_pos_z <= r.z;
        i_current_time <= r.now;
        do @(posedge i_clk); while (o_stall);
        a = table_apply(r);
        answers_due.push_back(a);
        i_valid <= 1'b0;
    endtask

    // Wait for every result, then let the block settle before touching the register
    task automatic drain_and_write(logic [31:0] v);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        age_limit = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request rand_request(logic [31:0] now);
        t_request r;
        int p;
        p = $urandom_range(0, 99);
        r.op = p < 40 ? OP_UPDATE : p < 65 ? OP_LOOKUP : p < 90 ? OP_NEAREST : OP_PURGE;
        if (known_ids.size() > 0 && $urandom_range(0, 3) != 0)
            r.id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        else r.id = $urandom;
        if (r.op == OP_UPDATE && known_ids.size() < 90) known_ids.push_back(r.id);
        r.x = rand_coord(); r.y = rand_coord(); r.z = rand_coord();
        r.now = ($urandom_range(0, 7) == 0) ? $urandom : now;
        return r;
    endfunction

    typedef struct {
        t_request req;
        bit       typed;
        t_answer  ans;
    } t_row;

    t_row rows[$];
    logic [31:0] clock_s;

    initial begin
        errors = 0; calm = 0;
        i_valid = 0; i_cfg_we = 0; i_cfg_wdata = '0;
        i_opcode = OP_UPDATE; i_entry_id = '0; i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_current_time = '0;
        i_rst_n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 0; tbl_key[i] = 0; tbl_x[i] = 0; tbl_y[i] = 0; tbl_z[i] = 0;
            tbl_stamp[i] = 0;
        end
        age_limit = AGE_LIMIT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed rows: empty table cases typed in, the rest from the predictor
        rows = '{
            '{'{OP_NEAREST, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
              '{ST_EMPTY, 32'd0, 32'd0, 32'd0, 32'd0, 7'd0}},
            '{'{OP_LOOKUP, 32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
              '{ST_NOT_FOUND, 32'd0, 32'd0, 32'd0, 32'd0, 7'd0}},
            '{'{OP_PURGE, 32'd0, 32'd0, 32'd0, 32'd0, 32'hffff_ffff}, 1,
              '{ST_OK, 32'd0, 32'd0, 32'd0, 32'd0, 7'd0}},
            '{'{OP_UPDATE, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0}, 0, '0},
            '{'{OP_UPDATE, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'd100}, 0, '0},
            '{'{OP_UPDATE, 32'h5555_aaaa, 32'd5, 32'hffff_fffb, 32'd0, 32'hffff_ffff}, 0, '0},
            '{'{OP_LOOKUP, 32'h0, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '0},
            '{'{OP_LOOKUP, 32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '0},
            '{'{OP_NEAREST, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0}, 0, '0},
            '{'{OP_NEAREST, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0}, 0, '0},
            '{'{OP_NEAREST, 32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0}, 0, '0},
            // tie: same point stored under a second id, lower slot must win
            '{'{OP_UPDATE, 32'h1234_5678, 32'd5, 32'hffff_fffb, 32'd0, 32'd50}, 0, '0},
            '{'{OP_NEAREST, 32'd0, 32'd5, 32'hffff_fffb, 32'd0, 32'd0}, 0, '0},
            // overwrite an existing id
            '{'{OP_UPDATE, 32'h0, 32'd1, 32'd2, 32'd3, 32'd10}, 0, '0},
            '{'{OP_LOOKUP, 32'h0, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '0},
            // stamp in the future stays, stale ones go
            '{'{OP_PURGE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd200}, 0, '0},
            '{'{OP_PURGE, 32'd0, 32'd0, 32'd0, 32'd0, 32'hffff_ffff}, 0, '0},
            '{'{OP_NEAREST, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '0}
        };
        foreach (rows[k]) begin
            if (rows[k].typed) begin
                void'(table_apply(rows[k].req));
                send_typed(rows[k].req, rows[k].ans);
            end else send(rows[k].req);
        end

        // Fill the table until full, then check the full case
        drain_and_write(32'd0);
        for (int i = 0; i < DEPTH + 2; i++)
            send('{OP_UPDATE, 32'h9000_0000 + i, $urandom, $urandom, $urandom, 32'd1000});
        send('{OP_NEAREST, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        send('{OP_PURGE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1000});
        send('{OP_PURGE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1001});

        // Random phases over several age limits
        clock_s = 32'd2000;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: drain_and_write(32'hffff_ffff);
                1: drain_and_write($urandom_range(1, 40));
                2: drain_and_write(32'd3);
                3: drain_and_write($urandom);
                default: drain_and_write(AGE_LIMIT_RESET);
            endcase
            if (ph == 4) calm = 1;
            for (int n = 0; n < 110; n++) begin
                clock_s += $urandom_range(0, 4);
                send(rand_request(clock_s));
                if (ph == 2 && n == 50)
                    while (answers_due.size() != 0) @(posedge i_clk);
            end
        end

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("position_table_nearest_search verification clean");
        else
            $display("position_table_nearest_search verification failed");
        $finish;
    end

    // Send with a hand-written answer; predictor already updated by the caller
    task automatic send_typed(t_request r, t_answer a);
        @(posedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= r.op; i_entry_id <= r.id;
        i_pos_x <= r.x; i_pos_y <= r.y; i_pos_z <= r.z;
        i_current_time <= r.now;
        do @(posedge i_clk); while (o_stall);
        answers_due.push_back(a);
        i_valid <= 1'b0;
    endtask
endmodule
